// File: hw/rtl/eds2d_pkg.sv
// Shared types, constants and reset values of the diffusion stencil block.
package eds2d_pkg;

  // Grid limits used when the top level is not given other values
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // Fixed field widths
  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int DIM_W      = 7;
  localparam int COORD_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Commands carried by an input item
  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IN_USE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IN_USE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE = 2'd3;

  // Configuration reset values
  localparam logic [GAIN_W-1:0]        STEP_GAIN_RST     = 16'd6554;
  localparam logic [DIM_W-1:0]         WIDTH_RST         = 7'd64;
  localparam logic [DIM_W-1:0]         HEIGHT_RST        = 7'd64;
  localparam logic signed [DATA_W-1:0] INITIAL_VALUE_RST = 32'sd65536000;

  // Result status codes
  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

endpackage

// File: hw/rtl/eds2d_in_if.sv
// Input channel of the diffusion stencil block: command, cell coordinates and write data.
interface eds2d_in_if
  import eds2d_pkg::*;
();
  logic                      valid;
  logic                      ready;
  cmd_t                      cmd;
  logic [COORD_W-1:0]        col;
  logic [COORD_W-1:0]        row;
  logic signed [DATA_W-1:0]  write_data;

  modport source (output valid, cmd, col, row, write_data, input ready);
  modport sink   (input valid, cmd, col, row, write_data, output ready);
endinterface

// File: hw/rtl/eds2d_out_if.sv
// Result channel of the diffusion stencil block: cell value and status.
interface eds2d_out_if
  import eds2d_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  cell_value;
  logic                      status;

  modport source (output valid, cell_value, status, input ready);
  modport sink   (input valid, cell_value, status, output ready);
endinterface

// File: hw/rtl/explicit_diffusion_stencil_2d_top.sv
// Diffusion stencil top level: grid store, row buffer, sweep control and stencil pipeline.
//
// Usage: every item on in_ch (cmd, col, row, write_data) gives one item on
// out_ch (cell_value, status). Commands: init clears the grid and places
// initial_value at the centre cell; step advances one explicit diffusion
// timestep over the interior; read returns one cell; write sets one cell.
// A coordinate outside the grid in use gives status 1 and value 0.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// The sweeps are set by the single write port of the grid store (one entry a cycle)
// and its single read port during step (one cell a cycle). One item is in work at a time.
// After reset the block first clears the store and places the default initial value;
// in_ch.ready stays low while the store is cleared.
// The result sits in an output register; a new item is accepted while it
// waits, and the block holds its next result until out_ch.ready is seen.
module explicit_diffusion_stencil_2d_top
  import eds2d_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  eds2d_in_if.sink              in_ch,
  eds2d_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW           = $clog2(MAX_WIDTH);
  localparam int RW           = $clog2(MAX_HEIGHT);
  localparam int AW           = RW + CW;
  localparam int STORE_DEPTH  = 1 << AW;
  localparam int BUF_DEPTH    = 2 << CW;
  localparam int XCW          = (CW > DIM_W) ? CW : DIM_W;
  localparam int YCW          = (RW > DIM_W) ? RW : DIM_W;
  localparam int W_LIM        = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
  localparam int H_LIM        = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_RDWAIT,
    S_STEP,
    S_DRAIN,
    S_FIN
  } state_t;

  // Configuration registers
  logic [GAIN_W-1:0]        step_gain_r;
  logic [DIM_W-1:0]         width_r;
  logic [DIM_W-1:0]         height_r;
  logic signed [DATA_W-1:0] init_value_r;

  // Control
  state_t                   state_r, state_nxt;
  logic [CW-1:0]            x_r, x_nxt;
  logic [RW-1:0]            y_r, y_nxt;
  logic [AW-1:0]            clr_addr_r, clr_addr_nxt;
  logic                     report_r, report_nxt;
  logic signed [DATA_W-1:0] res_value_r, res_value_nxt;
  logic                     res_status_r, res_status_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_status_r, out_status_nxt;

  // Memories
  logic signed [DATA_W-1:0] store_mem [STORE_DEPTH];
  logic signed [DATA_W-1:0] rowbuf_mem [BUF_DEPTH];
  logic signed [DATA_W-1:0] store_q;
  logic signed [DATA_W-1:0] above_q;
  logic signed [DATA_W-1:0] cur_q;
  logic [AW-1:0]            store_raddr;
  logic                     store_we;
  logic [AW-1:0]            store_waddr;
  logic signed [DATA_W-1:0] store_wdata;
  logic [CW:0]              buf_above_addr;
  logic [CW:0]              buf_cur_addr;
  logic [CW:0]              buf_waddr;

  // Stencil pipeline
  logic                     issue;
  logic                     d_valid_r;
  logic [CW-1:0]            d_x_r;
  logic [RW-1:0]            d_y_r;
  logic signed [DATA_W-1:0] left_r, mid_r, above_d_r, below_d_r;
  logic                     s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic [AW-1:0]            s1_addr_r, s2_addr_r, s3_addr_r, s4_addr_r;
  logic signed [DATA_W-1:0] s1_c_r, s2_c_r, s3_c_r, s4_c_r;
  logic signed [33:0]       s1_nsum_r;
  logic signed [34:0]       s2_lap_r;
  logic signed [51:0]       s3_prod_r;
  logic signed [35:0]       s4_delta_r;

  logic signed [33:0]       nsum;
  logic signed [34:0]       lap;
  logic signed [51:0]       prod;
  logic signed [51:0]       prod_rnd;
  logic signed [36:0]       upd_sum;
  logic signed [DATA_W-1:0] upd_sat;
  logic                     d_interior;

  // Clamped grid size and derived positions
  logic [DIM_W-1:0]         w_cl, h_cl;
  logic                     in_outside;
  logic [AW-1:0]            in_addr;
  logic [AW-1:0]            centre_addr;
  logic                     x_last, y_last;

  always_comb begin
    if (width_r < 7'd3) begin
      w_cl = 7'd3;
    end else if (width_r > DIM_W'(W_LIM)) begin
      w_cl = DIM_W'(W_LIM);
    end else begin
      w_cl = width_r;
    end
    if (height_r < 7'd3) begin
      h_cl = 7'd3;
    end else if (height_r > DIM_W'(H_LIM)) begin
      h_cl = DIM_W'(H_LIM);
    end else begin
      h_cl = height_r;
    end
  end

  assign in_outside  = ({1'b0, in_ch.col} >= w_cl) || ({1'b0, in_ch.row} >= h_cl);
  assign in_addr     = {RW'(in_ch.row), CW'(in_ch.col)};
  assign centre_addr = {RW'(h_cl >> 1), CW'(w_cl >> 1)};
  assign x_last      = (XCW'(x_r) == XCW'(w_cl - 7'd1));
  assign y_last      = (YCW'(y_r) == YCW'(h_cl - 7'd1));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_gain_r  <= STEP_GAIN_RST;
      width_r      <= WIDTH_RST;
      height_r     <= HEIGHT_RST;
      init_value_r <= INITIAL_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_GAIN:     step_gain_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_WIDTH_IN_USE:  width_r      <= cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT_IN_USE: height_r     <= cfg_wdata[DIM_W-1:0];
        CFG_INITIAL_VALUE: init_value_r <= $signed(cfg_wdata[DATA_W-1:0]);
        default: ;
      endcase
    end
  end

  // Sequence commands and sweeps
  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    clr_addr_nxt   = clr_addr_r;
    report_nxt     = report_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    issue          = 1'b0;
    store_raddr    = {y_r, x_r};
    store_we       = 1'b0;
    store_waddr    = s4_addr_r;
    store_wdata    = upd_sat;

    unique case (state_r)
      S_IDLE: begin
        store_raddr = in_addr;
        if (in_ch.valid) begin
          res_value_nxt  = '0;
          res_status_nxt = STATUS_DONE;
          unique case (in_ch.cmd)
            CMD_INIT: begin
              clr_addr_nxt = '0;
              report_nxt   = 1'b1;
              state_nxt    = S_CLEAR;
            end
            CMD_STEP: begin
              x_nxt     = '0;
              y_nxt     = '0;
              state_nxt = S_STEP;
            end
            CMD_READ: begin
              if (in_outside) begin
                res_status_nxt = STATUS_RANGE;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_RDWAIT;
              end
            end
            CMD_WRITE: begin
              if (in_outside) begin
                res_status_nxt = STATUS_RANGE;
              end else begin
                store_we    = 1'b1;
                store_waddr = in_addr;
                store_wdata = in_ch.write_data;
              end
              state_nxt = S_FIN;
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        store_we     = 1'b1;
        store_waddr  = clr_addr_r;
        store_wdata  = (clr_addr_r == centre_addr) ? init_value_r : '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == {AW{1'b1}}) begin
          state_nxt = report_r ? S_FIN : S_IDLE;
        end
      end
      S_RDWAIT: begin
        res_value_nxt = store_q;
        state_nxt     = S_FIN;
      end
      S_STEP: begin
        issue = 1'b1;
        store_we = s4_valid_r;
        if (x_last) begin
          x_nxt = '0;
          y_nxt = y_r + 1'b1;
          if (y_last) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
      S_DRAIN: begin
        store_we = s4_valid_r;
        if (!(d_valid_r || s1_valid_r || s2_valid_r || s3_valid_r || s4_valid_r)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, counters and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      report_r     <= 1'b0;
      x_r          <= '0;
      y_r          <= '0;
      out_valid_r  <= 1'b0;
      res_status_r <= STATUS_DONE;
      res_value_r  <= '0;
      out_value_r  <= '0;
      out_status_r <= STATUS_DONE;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      report_r     <= report_nxt;
      x_r          <= x_nxt;
      y_r          <= y_nxt;
      out_valid_r  <= out_valid_nxt;
      res_status_r <= res_status_nxt;
      res_value_r  <= res_value_nxt;
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_value = out_value_r;
  assign out_ch.status     = out_status_r;

  // Grid store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    store_q <= store_mem[store_raddr];
  end

  // Row buffer: row r lives in half r[0]; read two rows back and one row back
  assign buf_above_addr = {y_r[0], x_r};
  assign buf_cur_addr   = {~y_r[0], x_r};
  assign buf_waddr      = {d_y_r[0], d_x_r};

  always_ff @(posedge clk) begin
    if (d_valid_r) begin
      rowbuf_mem[buf_waddr] <= store_q;
    end
    above_q <= rowbuf_mem[buf_above_addr];
    cur_q   <= rowbuf_mem[buf_cur_addr];
  end

  // Stencil arithmetic between pipeline registers
  assign d_interior = (d_y_r >= RW'(2)) && (d_x_r >= CW'(2));

  assign nsum = $signed({{2{left_r[31]}}, left_r}) + $signed({{2{cur_q[31]}}, cur_q})
              + $signed({{2{above_d_r[31]}}, above_d_r})
              + $signed({{2{below_d_r[31]}}, below_d_r});
  assign lap  = $signed({s1_nsum_r[33], s1_nsum_r}) - $signed({s1_c_r[31], s1_c_r, 2'b00});
  assign prod = s2_lap_r * $signed({1'b0, step_gain_r});
  assign prod_rnd = s3_prod_r + 52'sd32768;
  assign upd_sum  = $signed({{5{s4_c_r[31]}}, s4_c_r}) + $signed({s4_delta_r[35], s4_delta_r});

  // Saturate the updated cell to 32 bits
  always_comb begin
    if (upd_sum > 37'sh0_7FFF_FFFF) begin
      upd_sat = 32'sh7FFF_FFFF;
    end else if (upd_sum < -37'sh0_8000_0000) begin
      upd_sat = 32'sh8000_0000;
    end else begin
      upd_sat = upd_sum[31:0];
    end
  end

  // Advance pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r  <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      d_valid_r  <= issue;
      s1_valid_r <= d_valid_r && d_interior;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  // Advance pipeline payload and the column window
  always_ff @(posedge clk) begin
    d_x_r <= x_r;
    d_y_r <= y_r;
    if (d_valid_r) begin
      left_r    <= mid_r;
      mid_r     <= cur_q;
      above_d_r <= above_q;
      below_d_r <= store_q;
    end
    s1_nsum_r  <= nsum;
    s1_c_r     <= mid_r;
    s1_addr_r  <= {d_y_r - 1'b1, d_x_r - 1'b1};
    s2_lap_r   <= lap;
    s2_c_r     <= s1_c_r;
    s2_addr_r  <= s1_addr_r;
    s3_prod_r  <= prod;
    s3_c_r     <= s2_c_r;
    s3_addr_r  <= s2_addr_r;
    s4_delta_r <= prod_rnd[51:16];
    s4_c_r     <= s3_c_r;
    s4_addr_r  <= s3_addr_r;
  end

  // Stencil writes never touch row 0 or column 0
  a_interior_write: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r |-> (s4_addr_r[AW-1:CW] != '0) && (s4_addr_r[CW-1:0] != '0))
    else $error("stencil write to a boundary cell");

  // No item is taken while the store is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ch.ready)
    else $error("ready raised during clearing sweep");

  // A result appears only from the finishing state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside finishing state");

  // The stencil pipeline is empty whenever an item can be taken
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      !(d_valid_r || s1_valid_r || s2_valid_r || s3_valid_r || s4_valid_r))
    else $error("stencil pipeline busy while idle");

  // Row buffer fill never hits an entry read in the same cycle
  a_rowbuf_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && d_valid_r) |-> (buf_waddr != buf_above_addr) && (buf_waddr != buf_cur_addr))
    else $error("row buffer write collides with a read");

endmodule

// File: dv/eds2d_grid_monitor.sv
`timescale 1ns / 1ps
// Result checker for the diffusion stencil testbench: grid predictor and in-order comparison.
module eds2d_grid_monitor
  import eds2d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  eds2d_in_if                   in_mon,
  eds2d_out_if                  out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  localparam int GRID_W = MAX_WIDTH_DEF;
  localparam int GRID_H = MAX_HEIGHT_DEF;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [DATA_W-1:0] cell_value;
    logic                     status;
  } cell_result_t;

  // Shadow copy of the grid and the registers
  logic signed [DATA_W-1:0] conc [GRID_W*GRID_H];
  logic [GAIN_W-1:0]        gain_reg;
  logic [DIM_W-1:0]         cols_code;
  logic [DIM_W-1:0]         rows_code;
  logic signed [DATA_W-1:0] seed_value;

  cell_result_t awaited_results [$];
  int n_fail = 0;
  int n_pending = 0;

  assign fail_count = n_fail;
  assign pending    = n_pending;

  // Grid size actually used for a register code
  function automatic int span_of(logic [DIM_W-1:0] code, int top_limit);
    if (code < 3) return 3;
    if (int'(code) > top_limit) return top_limit;
    return int'(code);
  endfunction

  // Clear the grid and place the seed at the centre cell
  function automatic void seed_grid();
    int w;
    int h;
    w = span_of(cols_code, GRID_W);
    h = span_of(rows_code, GRID_H);
    foreach (conc[i]) conc[i] = '0;
    conc[(h / 2) * GRID_W + (w / 2)] = seed_value;
  endfunction

  // Advance one timestep over the interior from the old values
  function automatic void advance_grid();
    logic signed [DATA_W-1:0] prev [GRID_W*GRID_H];
    int     w;
    int     h;
    int     idx;
    longint lap;
    longint delta;
    longint sum;
    w = span_of(cols_code, GRID_W);
    h = span_of(rows_code, GRID_H);
    prev = conc;
    for (int y = 1; y < h - 1; y++) begin
      for (int x = 1; x < w - 1; x++) begin
        idx = y * GRID_W + x;
        lap = longint'(prev[idx-1]) + longint'(prev[idx+1])
            + longint'(prev[idx-GRID_W]) + longint'(prev[idx+GRID_W])
            - 4 * longint'(prev[idx]);
        // round half up to Q16.16
        delta = (lap * longint'({1'b0, gain_reg}) + 64'sd32768) >>> 16;
        sum = longint'(prev[idx]) + delta;
        if (sum > Q_MAX) begin
          conc[idx] = 32'sh7FFFFFFF;
        end else if (sum < Q_MIN) begin
          conc[idx] = 32'sh80000000;
        end else begin
          conc[idx] = sum[DATA_W-1:0];
        end
      end
    end
  endfunction

  // Apply one command to the shadow grid and return its result
  function automatic cell_result_t predict_cell(cmd_t op, logic [COORD_W-1:0] c,
                                                logic [COORD_W-1:0] r,
                                                logic signed [DATA_W-1:0] d);
    cell_result_t res;
    int w;
    int h;
    res.cell_value = '0;
    res.status     = STATUS_DONE;
    w = span_of(cols_code, GRID_W);
    h = span_of(rows_code, GRID_H);
    case (op)
      CMD_INIT: seed_grid();
      CMD_STEP: advance_grid();
      default: begin
        if (int'(c) >= w || int'(r) >= h) begin
          res.status = STATUS_RANGE;
        end else if (op == CMD_READ) begin
          res.cell_value = conc[int'(r) * GRID_W + int'(c)];
        end else begin
          conc[int'(r) * GRID_W + int'(c)] = d;
        end
      end
    endcase
    return res;
  endfunction

  // Track registers, predict accepted items and compare accepted results
  always @(posedge clk) begin
    cell_result_t due;
    if (!rst_n) begin
      gain_reg   = STEP_GAIN_RST;
      cols_code  = WIDTH_RST;
      rows_code  = HEIGHT_RST;
      seed_value = INITIAL_VALUE_RST;
      seed_grid();
      awaited_results.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_STEP_GAIN:     gain_reg   = cfg_wdata[GAIN_W-1:0];
          CFG_WIDTH_IN_USE:  cols_code  = cfg_wdata[DIM_W-1:0];
          CFG_HEIGHT_IN_USE: rows_code  = cfg_wdata[DIM_W-1:0];
          CFG_INITIAL_VALUE: seed_value = cfg_wdata[DATA_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting: a result never leaves on its own accept edge
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (awaited_results.size() == 0) begin
          $error("result with no item waiting: cell_value %0d, status %0d",
                 out_mon.cell_value, out_mon.status);
          n_fail++;
        end else begin
          due = awaited_results.pop_front();
          if (out_mon.cell_value !== due.cell_value) begin
            $error("cell_value mismatch: expected %0d, got %0d",
                   due.cell_value, out_mon.cell_value);
            n_fail++;
          end
          if (out_mon.status !== due.status) begin
            $error("status mismatch: expected %0d, got %0d", due.status, out_mon.status);
            n_fail++;
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        awaited_results.push_back(predict_cell(in_mon.cmd, in_mon.col, in_mon.row,
                                               in_mon.write_data));
      end
    end
    n_pending = awaited_results.size();
  end

endmodule

// File: dv/explicit_diffusion_stencil_2d_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the diffusion stencil block: stimulus, configuration and verdict.
module explicit_diffusion_stencil_2d_top_tb;
  import eds2d_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bit quiet_phase = 1'b0;  // no gaps on either side while set
  int grid_cols = MAX_WIDTH_DEF;
  int grid_rows = MAX_HEIGHT_DEF;
  int fail_count;
  int pending;

  eds2d_in_if  in_ch ();
  eds2d_out_if out_ch ();

  explicit_diffusion_stencil_2d_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  eds2d_grid_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Give up well beyond the slowest correct run
  initial begin
    #60_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: stall a random number of cycles before taking each item
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  function automatic int span_of(logic [DIM_W-1:0] code, int top_limit);
    if (code < 3) return 3;
    if (int'(code) > top_limit) return top_limit;
    return int'(code);
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(cmd_t op, int c, int r, logic [DATA_W-1:0] d);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.cmd        <= op;
    in_ch.col        <= c[COORD_W-1:0];
    in_ch.row        <= r[COORD_W-1:0];
    in_ch.write_data <= d;
    in_ch.valid      <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Drop valid and hold until every result has come back
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  // Write all four registers while the block is idle; junk in the unused upper bits
  task automatic set_config(logic [GAIN_W-1:0] gain, logic [DIM_W-1:0] wcode,
                            logic [DIM_W-1:0] hcode, logic [DATA_W-1:0] seed);
    logic [CFG_DATA_W-1:0] junk;
    drain();
    junk = $urandom;
    write_reg(CFG_STEP_GAIN, {junk[31:GAIN_W], gain});
    junk = $urandom;
    write_reg(CFG_WIDTH_IN_USE, {junk[31:DIM_W], wcode});
    junk = $urandom;
    write_reg(CFG_HEIGHT_IN_USE, {junk[31:DIM_W], hcode});
    write_reg(CFG_INITIAL_VALUE, seed);
    @(negedge clk);
    cfg_we <= 1'b0;
    grid_cols = span_of(wcode, MAX_WIDTH_DEF);
    grid_rows = span_of(hcode, MAX_HEIGHT_DEF);
  endtask

  // One random command, mostly inside the grid in use
  task automatic send_random_item();
    cmd_t              op;
    int                sel;
    int                c;
    int                r;
    logic [DATA_W-1:0] d;
    sel = $urandom_range(0, 99);
    if (sel < 5) op = CMD_INIT;
    else if (sel < 20) op = CMD_STEP;
    else if (sel < 60) op = CMD_WRITE;
    else op = CMD_READ;
    if ($urandom_range(0, 4) == 0) begin
      c = $urandom_range(0, 63);
      r = $urandom_range(0, 63);
    end else begin
      c = $urandom_range(0, grid_cols - 1);
      r = $urandom_range(0, grid_rows - 1);
    end
    case ($urandom_range(0, 3))
      0: d = $urandom;
      1: d = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      2: d = $urandom_range(0, 32'h0FFFFFFF);
      default: d = -$urandom_range(0, 32'h0FFFFFFF);
    endcase
    send_item(op, c, r, d);
  endtask

  initial begin
    logic [DIM_W-1:0] wcode;
    logic [DIM_W-1:0] hcode;
    int               n_items;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_INIT;
    in_ch.col        = '0;
    in_ch.row        = '0;
    in_ch.write_data = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset grid: centre, corners, boundary writes and one full-size step
    send_item(CMD_READ, 32, 32, 32'h0);
    send_item(CMD_READ, 0, 0, 32'hFFFFFFFF);
    send_item(CMD_READ, 63, 63, 32'h0);
    send_item(CMD_WRITE, 63, 0, 32'h7FFFFFFF);
    send_item(CMD_WRITE, 0, 63, 32'h80000000);
    send_item(CMD_READ, 63, 0, 32'h0);
    send_item(CMD_READ, 0, 63, 32'h0);
    send_item(CMD_STEP, 0, 0, 32'h0);
    send_item(CMD_READ, 32, 32, 32'h0);
    send_item(CMD_READ, 31, 32, 32'h0);
    send_item(CMD_READ, 32, 31, 32'h0);
    send_item(CMD_READ, 63, 0, 32'h0);

    // Full gain on a tiny grid: saturation and coordinates just outside
    set_config(16'hFFFF, 7'd5, 7'd4, 32'h80000000);
    send_item(CMD_INIT, 0, 0, 32'h0);
    send_item(CMD_READ, 2, 2, 32'h0);
    send_item(CMD_READ, 5, 0, 32'h0);
    send_item(CMD_WRITE, 0, 4, 32'h12345678);
    send_item(CMD_WRITE, 1, 1, 32'h7FFFFFFF);
    send_item(CMD_STEP, 0, 0, 32'h0);
    send_item(CMD_READ, 1, 1, 32'h0);
    send_item(CMD_READ, 2, 1, 32'h0);
    send_item(CMD_READ, 2, 2, 32'h0);

    // Resize without init: cells keep their place
    set_config(16'd1, 7'd7, 7'd6, 32'h0);
    send_item(CMD_READ, 1, 1, 32'h0);
    send_item(CMD_STEP, 0, 0, 32'h0);

    // Random phases, each opened by an init so the grid holds a known seed
    for (int phase = 0; phase < 7; phase++) begin
      n_items = 17;
      case (phase)
        0: set_config(16'hFFFF, 7'd3, 7'd3, 32'h7FFFFFFF);
        1: set_config(16'h0000, 7'd127, 7'd0, 32'h80000000);
        2: begin
          set_config(16'($urandom_range(0, 65535)), 7'd64, 7'd64, $urandom);
          n_items = 10;
        end
        default: begin
          wcode = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(3, 12));
          hcode = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(3, 12));
          set_config(16'($urandom_range(0, 65535)), wcode, hcode, $urandom);
        end
      endcase
      quiet_phase = (phase == 1 || phase == 4);
      send_item(CMD_INIT, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      repeat (n_items) send_random_item();
    end
    quiet_phase = 1'b0;

    // Wait out the last results, then give the verdict
    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
